[hdl/rhv_pkg.sv]
package rhv_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 24;
   localparam int unsigned ROM_SIZE_W = 24;
   localparam int unsigned RAM_SIZE_W = 18;

   localparam int unsigned RHV_MAX_ROM_CODE = 8;
   localparam int unsigned ROM_CODE_LIMIT   = 8;

   localparam logic [POS_W-1:0] POS_MAX       = 24'hFFFFFF;
   localparam logic [POS_W-1:0] HDR_SUM_FIRST = 24'h000134;
   localparam logic [POS_W-1:0] HDR_SUM_LAST  = 24'h00014C;
   localparam logic [POS_W-1:0] HDR_TYPE      = 24'h000147;
   localparam logic [POS_W-1:0] HDR_ROM       = 24'h000148;
   localparam logic [POS_W-1:0] HDR_RAM       = 24'h000149;
   localparam logic [POS_W-1:0] HDR_CHECK     = 24'h00014D;
   localparam logic [POS_W-1:0] MIN_IMAGE     = 24'h000150;

   localparam logic [ROM_SIZE_W-1:0] ROM_UNIT = 24'd32768;

   localparam logic [BYTE_W-1:0] RAM_CODE_NONE = 8'h00;
   localparam logic [BYTE_W-1:0] RAM_CODE_8K   = 8'h02;
   localparam logic [BYTE_W-1:0] RAM_CODE_32K  = 8'h03;
   localparam logic [BYTE_W-1:0] RAM_CODE_128K = 8'h04;
   localparam logic [BYTE_W-1:0] RAM_CODE_64K  = 8'h05;

   // cartridge type ranges that a header may legally declare
   localparam logic [BYTE_W-1:0] TYPE_ROM_ONLY   = 8'h00;
   localparam logic [BYTE_W-1:0] TYPE_LOW_FIRST  = 8'h01;
   localparam logic [BYTE_W-1:0] TYPE_LOW_LAST   = 8'h03;
   localparam logic [BYTE_W-1:0] TYPE_HIGH_FIRST = 8'h0F;
   localparam logic [BYTE_W-1:0] TYPE_HIGH_LAST  = 8'h13;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_TOO_SMALL    = 3'd1,
      STATUS_CHECKSUM_BAD = 3'd2,
      STATUS_UNKNOWN_ROM  = 3'd3,
      STATUS_SIZE_MISMATCH = 3'd4,
      STATUS_UNKNOWN_TYPE = 3'd5,
      STATUS_BAD_MAPPER   = 3'd6,
      STATUS_UNKNOWN_RAM  = 3'd7
   } status_type;

endpackage

[hdl/rhv_req_if.sv]
interface rhv_req_if import rhv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic              final_byte;

   modport source (output valid, output byte_value, output final_byte, input ready);
   modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

[hdl/rhv_rsp_if.sv]
interface rhv_rsp_if import rhv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [ROM_SIZE_W-1:0] rom_size_bytes;
   logic [RAM_SIZE_W-1:0] ram_size_bytes;
   logic [BYTE_W-1:0]     cart_type_code;

   modport source (output valid, output status, output rom_size_bytes,
                   output ram_size_bytes, output cart_type_code, input ready);
   modport sink   (input valid, input status, input rom_size_bytes,
                   input ram_size_bytes, input cart_type_code, output ready);
endinterface

[hdl/rom_header_validator.sv]
// Channel  | Direction | Handshake           | Payload
// req_ch   | in        | valid / ready       | byte_value, final_byte
// rsp_ch   | out       | valid / ready       | status, rom_size_bytes, ram_size_bytes,
//          |           |                     | cart_type_code
//
// One byte per cycle, unless a final byte waits in the input register for a stalled result.
// A byte sits in the input register, then the header state updates and, on the final byte,
// the verdict is loaded into the result register, which also holds the result valid flag.
// Synchronous active-high reset clears the position counter, captured header bytes and
// both valid flags. A stalled result only holds back a final byte; other bytes keep
// flowing while the result waits.
module rom_header_validator import rhv_pkg::*; #(
   parameter int unsigned MAX_ROM_CODE = RHV_MAX_ROM_CODE
) (
   input logic        clock,
   input logic        reset,
   rhv_req_if.sink    req_ch,
   rhv_rsp_if.source  rsp_ch
);

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_final_ff;

   // header state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] rom_code_ff, rom_code_in;
   logic [BYTE_W-1:0] ram_code_ff, ram_code_in;
   logic [BYTE_W-1:0] check_ff, check_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [ROM_SIZE_W-1:0] rom_size_ff, rom_size_in;
   logic [RAM_SIZE_W-1:0] ram_size_ff, ram_size_in;
   logic [BYTE_W-1:0]     cart_type_ff;

   logic                  out_free;
   logic                  s1_go;
   logic                  req_take;
   logic [POS_W-1:0]      count;
   logic [ROM_SIZE_W-1:0] declared;
   logic [RAM_SIZE_W-1:0] ram_bytes;
   logic                  ram_known;
   logic                  type_known;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && (!s1_final_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_go);

   // fold the current byte into the header state
   always_comb begin
      sum_in      = sum_ff;
      type_in     = type_ff;
      rom_code_in = rom_code_ff;
      ram_code_in = ram_code_ff;
      check_in    = check_ff;
      if (pos_ff >= HDR_SUM_FIRST && pos_ff <= HDR_SUM_LAST) begin
         sum_in = sum_ff - s1_byte_ff - 8'd1;
      end
      if (pos_ff == HDR_TYPE) begin
         type_in = s1_byte_ff;
      end
      if (pos_ff == HDR_ROM) begin
         rom_code_in = s1_byte_ff;
      end
      if (pos_ff == HDR_RAM) begin
         ram_code_in = s1_byte_ff;
      end
      if (pos_ff == HDR_CHECK) begin
         check_in = s1_byte_ff;
      end
      count = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 24'd1;
   end

   assign pos_in   = count;
   assign declared = ROM_UNIT << rom_code_in[3:0];

   always_comb begin
      ram_known = 1'b1;
      unique case (ram_code_in)
         RAM_CODE_NONE: ram_bytes = 18'd0;
         RAM_CODE_8K:   ram_bytes = 18'd8192;
         RAM_CODE_32K:  ram_bytes = 18'd32768;
         RAM_CODE_128K: ram_bytes = 18'd131072;
         RAM_CODE_64K:  ram_bytes = 18'd65536;
         default: begin
            ram_bytes = 18'd0;
            ram_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (type_in) inside
         [TYPE_LOW_FIRST:TYPE_LOW_LAST], [TYPE_HIGH_FIRST:TYPE_HIGH_LAST]: type_known = 1'b1;
         default: type_known = 1'b0;
      endcase
   end

   // verdict in priority order
   always_comb begin
      rom_size_in = '0;
      ram_size_in = '0;
      if (count < MIN_IMAGE) begin
         status_in = STATUS_TOO_SMALL;
      end else if (sum_in != check_in) begin
         status_in = STATUS_CHECKSUM_BAD;
      end else if (rom_code_in > BYTE_W'(MAX_ROM_CODE) ||
                   rom_code_in > BYTE_W'(ROM_CODE_LIMIT)) begin
         status_in = STATUS_UNKNOWN_ROM;
      end else if (declared != count) begin
         status_in = STATUS_SIZE_MISMATCH;
      end else if (type_in != TYPE_ROM_ONLY && !type_known) begin
         status_in = STATUS_UNKNOWN_TYPE;
      end else if (type_in != TYPE_ROM_ONLY && rom_code_in != '0) begin
         status_in = STATUS_BAD_MAPPER;
      end else if (!ram_known) begin
         status_in = STATUS_UNKNOWN_RAM;
      end else begin
         status_in   = STATUS_OK;
         rom_size_in = declared;
         ram_size_in = ram_bytes;
      end
   end

   assign rsp_valid_in = (s1_go && s1_final_ff) || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_ch.byte_value;
         s1_final_ff <= req_ch.final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         type_ff     <= '0;
         rom_code_ff <= '0;
         ram_code_ff <= '0;
         check_ff    <= '0;
      end else if (s1_go) begin
         if (s1_final_ff) begin
            // start a new image
            pos_ff      <= '0;
            sum_ff      <= '0;
            type_ff     <= '0;
            rom_code_ff <= '0;
            ram_code_ff <= '0;
            check_ff    <= '0;
         end else begin
            pos_ff      <= pos_in;
            sum_ff      <= sum_in;
            type_ff     <= type_in;
            rom_code_ff <= rom_code_in;
            ram_code_ff <= ram_code_in;
            check_ff    <= check_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_final_ff) begin
         status_ff    <= status_in;
         rom_size_ff  <= rom_size_in;
         ram_size_ff  <= ram_size_in;
         cart_type_ff <= type_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.rom_size_bytes = rom_size_ff;
   assign rsp_ch.ram_size_bytes = ram_size_ff;
   assign rsp_ch.cart_type_code = cart_type_ff;

   a_restart_after_final: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_final_ff |=> pos_ff == '0 && sum_ff == '0)
      else $error("header state not cleared after final byte");

   a_sizes_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_OK |-> rom_size_ff == '0 && ram_size_ff == '0)
      else $error("sizes reported with a failing status");

   a_ok_has_rom_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_OK |-> rom_size_ff >= ROM_UNIT)
      else $error("ok status without a ROM size");

   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(s1_go && s1_final_ff))
      else $error("result raised without a final byte");

endmodule
